// ===== rtl/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, entry and code types, and the ordering key shared by the queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int PRIO_W  = 16;
    localparam int OCC_W   = 5;
    localparam int KEY_W   = VAL_W + PRIO_W;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic        [PRIO_W-1:0] prio;
        logic signed [VAL_W-1:0]  value;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_ctrl;

    // Priority above the value with its sign flipped, so an unsigned compare
    // follows queue order.
    function automatic logic [KEY_W-1:0] order_key(input t_entry e);
        return {e.prio, ~e.value[VAL_W-1], e.value[VAL_W-2:0]};
    endfunction

endpackage

// ===== rtl/spq_if.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue channel interfaces
// Valid/ready channels for commands in and results out.
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*;;
    logic                     valid;
    logic                     ready;
    t_cmd                     command;
    logic signed [VAL_W-1:0]  item_value;
    logic        [PRIO_W-1:0] item_priority;

    modport source (output valid, output command, output item_value,
                    output item_priority, input ready);
    modport sink   (input valid, input command, input item_value,
                    input item_priority, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
    logic                     valid;
    logic                     ready;
    t_status                  status;
    logic signed [VAL_W-1:0]  removed_value;
    logic        [PRIO_W-1:0] removed_priority;
    logic        [OCC_W-1:0]  occupancy;

    modport source (output valid, output status, output removed_value,
                    output removed_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_priority, input occupancy, output ready);
endinterface

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; keeps it, takes the new entry or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  logic       i_occupied,
    input  logic       i_prev_stay,
    input  t_entry     i_prev_entry,
    input  t_entry     i_next_entry,
    output logic       o_stay,
    output t_entry     o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // An occupied entry that sorts at or before the new one stays put.
    assign o_stay  = i_occupied && (order_key(r_entry) <= order_key(i_new));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins && !o_stay) begin
            n_entry = i_prev_stay ? i_new : i_prev_entry;
        end else if (i_ctrl.rem) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted priority queue
// A row of DEPTH cells that keeps entries sorted by priority, then by value.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the i_in channel (insert or remove, with a value
// and a priority for inserts) and every command produces exactly one result
// transaction on o_out: a status, the removed head entry (zero unless one was
// removed) and the occupancy after the command.
// A command is latched when its transaction is accepted; in the following
// cycle every cell compares its entry with the new one in parallel and
// shifts, so the whole row updates at once and the result lands in the
// output register. The next command can be accepted only after that
// result is registered, so the block does not take a new command while
// the previous one is still in flight.
// The output register holds a result until the receiver takes it, and a
// command is only accepted when that register is empty or is being emptied
// at the accepting edge, so a waiting result does hold off the next command.
// If the receiver stalls, i_in.ready stays low until the pending result is
// taken.
// Reset empties the queue (the entry count goes to zero); cell contents are
// not cleared, as cells past the count are never read.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue import spq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    // Command latched at acceptance, executed in the following cycle.
    logic             r_busy;
    logic             n_busy;
    t_cmd             r_cmd;
    t_entry           r_item;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // Output register.
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [VAL_W-1:0]  r_rem_value;
    logic signed [VAL_W-1:0]  n_rem_value;
    logic        [PRIO_W-1:0] r_rem_prio;
    logic        [PRIO_W-1:0] n_rem_prio;
    logic        [OCC_W-1:0]  r_occ;
    logic        [OCC_W-1:0]  n_occ;

    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    t_cell_ctrl w_ctrl;

    logic [DEPTH-1:0] w_occupied;
    logic [DEPTH-1:0] w_stay;
    t_entry           w_entry [DEPTH];

    // A new command is taken only when no command is in flight and the output
    // register is empty or being emptied at this edge.
    assign i_in.ready = !r_busy && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    assign w_ctrl.ins = r_busy && (r_cmd == CMD_INSERT) && !w_full;
    assign w_ctrl.rem = r_busy && (r_cmd == CMD_REMOVE) && !w_empty;

    // The cell row. Every occupied cell whose entry sorts at or before the
    // new one stays; the first cell that does not stay takes the new entry
    // and every cell behind it takes its left neighbor's entry. On a remove
    // every cell takes its right neighbor's entry.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_stay;

        assign w_occupied[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_prev      = r_item;
            assign w_prev_stay = 1'b1;
        end else begin : g_body
            assign w_prev      = w_entry[g-1];
            assign w_prev_stay = w_stay[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = w_entry[g];
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_new        (r_item),
            .i_occupied   (w_occupied[g]),
            .i_prev_stay  (w_prev_stay),
            .i_prev_entry (w_prev),
            .i_next_entry (w_next),
            .o_stay       (w_stay[g]),
            .o_entry      (w_entry[g])
        );
    end

    // Next values for the control and result registers.
    always_comb begin
        n_busy      = r_busy;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_rem_value = r_rem_value;
        n_rem_prio  = r_rem_prio;
        n_occ       = r_occ;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.rem) begin
            n_count = r_count - CNT_W'(1);
        end

        if (r_busy) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            n_rem_value = '0;
            n_rem_prio  = '0;
            n_occ       = OCC_W'(n_count);
            if (r_cmd == CMD_INSERT) begin
                n_status = w_full ? ST_FULL : ST_INSERTED;
            end else if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status    = ST_REMOVED;
                n_rem_value = w_entry[0].value;
                n_rem_prio  = w_entry[0].prio;
            end
        end else if (w_accept) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= i_in.command;
            r_item.value <= i_in.item_value;
            r_item.prio  <= i_in.item_priority;
        end
        r_status    <= n_status;
        r_rem_value <= n_rem_value;
        r_rem_prio  <= n_rem_prio;
        r_occ       <= n_occ;
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_status;
    assign o_out.removed_value    = r_rem_value;
    assign o_out.removed_priority = r_rem_prio;
    assign o_out.occupancy        = r_occ;

    // The entry count never passes the capacity of the row.
    `SPQ_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "count exceeds depth")
    // A command in flight always finishes in the next cycle with a result ready.
    `SPQ_ASSERT_NXT(a_busy_done, r_busy, !r_busy && r_out_valid, "command did not finish")
    // An accepted insert into a queue with room grows it by exactly one.
    `SPQ_ASSERT_NXT(a_ins_grow, w_ctrl.ins, r_count == $past(r_count) + CNT_W'(1),
        "insert did not grow count")
    // An accepted remove from a non-empty queue shrinks it by exactly one.
    `SPQ_ASSERT_NXT(a_rem_shrink, w_ctrl.rem, r_count == $past(r_count) - CNT_W'(1),
        "remove did not shrink count")
    // A new command is never taken while the previous one is in flight.
    `SPQ_ASSERT_IMP(a_no_overlap, r_busy, !w_accept, "command accepted while busy")

endmodule

// ===== tb/sv/spq_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue result checker
// Watches both channels. It keeps a shadow copy of the queue and works out the
// result of every accepted command, then compares each result transaction
// with the oldest pending expectation.
// ----------------------------------------------------------------------------
module spq_result_checker import spq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_in_if    i_cmd,
    spq_out_if   i_res,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_inserted,
    output int   o_removed,
    output int   o_rejected,
    output int   o_empty_hits
);

    typedef struct packed {
        t_status                  status;
        logic signed [VAL_W-1:0]  value;
        logic        [PRIO_W-1:0] prio;
        logic        [OCC_W-1:0]  occ;
    } t_outcome;

    t_entry   held_q [DEPTH];
    int       held_count;
    t_outcome awaited_q [$];
    int       bad_count;
    int       n_ins, n_rem, n_full, n_empty;

    // Priority first, then the value with its sign bit flipped, so that a
    // plain unsigned compare gives the queue order.
    function automatic logic [KEY_W-1:0] rank(input t_entry e);
        return {e.prio, e.value ^ 32'h8000_0000};
    endfunction

    function automatic t_outcome apply_command(input t_cmd cmd, input t_entry fresh);
        t_outcome res;
        int       pos;
        res = '0;
        if (cmd == CMD_INSERT) begin
            if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // A new entry goes after any entry that ranks equal to it.
                pos = 0;
                while (pos < held_count && rank(held_q[pos]) <= rank(fresh)) pos++;
                for (int i = held_count; i > pos; i--) held_q[i] = held_q[i-1];
                held_q[pos] = fresh;
                held_count++;
                res.status = ST_INSERTED;
            end
        end else if (held_count == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.status = ST_REMOVED;
            res.value  = held_q[0].value;
            res.prio   = held_q[0].prio;
            for (int i = 1; i < held_count; i++) held_q[i-1] = held_q[i];
            held_count--;
        end
        res.occ = OCC_W'(held_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want, seen;
        t_entry   fresh;
        if (!i_rst_n) begin
            held_count = 0;
            awaited_q.delete();
            bad_count = 0;
            n_ins = 0; n_rem = 0; n_full = 0; n_empty = 0;
        end else begin
            // Results are handled before commands: a result can never belong
            // to a command accepted at the same edge.
            if (i_res.valid && i_res.ready) begin
                seen.status = i_res.status;
                seen.value  = i_res.removed_value;
                seen.prio   = i_res.removed_priority;
                seen.occ    = i_res.occupancy;
                if (awaited_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("%0t: result with nothing pending: status %0d value %0d",
                                 $time, seen.status, seen.value);
                end else begin
                    want = awaited_q.pop_front();
                    if (seen !== want) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("%0t: mismatch, expected status %0d value %0d prio %0d occ %0d",
                                     $time, want.status, want.value, want.prio, want.occ);
                            $display("%0t:           got status %0d value %0d prio %0d occ %0d",
                                     $time, seen.status, seen.value, seen.prio, seen.occ);
                        end
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                fresh.prio  = i_cmd.item_priority;
                fresh.value = i_cmd.item_value;
                want = apply_command(i_cmd.command, fresh);
                case (want.status)
                    ST_INSERTED: n_ins++;
                    ST_REMOVED:  n_rem++;
                    ST_FULL:     n_full++;
                    ST_EMPTY:    n_empty++;
                    default: ;
                endcase
                awaited_q.push_back(want);
            end
        end
        o_mismatches  <= bad_count;
        o_outstanding <= awaited_q.size();
        o_inserted    <= n_ins;
        o_removed     <= n_rem;
        o_rejected    <= n_full;
        o_empty_hits  <= n_empty;
    end

endmodule

// ===== tb/sv/tb_sorted_priority_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove commands into the queue with random idle cycles
// and random back pressure, and lets a separate checker predict and compare
// every result transaction. The top gives the final verdict.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue import spq_pkg::*;;

    logic clk;
    logic rst_n;

    spq_in_if  in_ch ();
    spq_out_if out_ch ();

    int mismatches, outstanding;
    int n_inserted, n_removed, n_rejected, n_empty_hits;

    // While steady is set, neither the command side nor the result side
    // inserts idle cycles, so the block runs at its full rate for a while.
    logic steady;

    sorted_priority_queue uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    spq_result_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd         (in_ch),
        .i_res         (out_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_inserted    (n_inserted),
        .o_removed     (n_removed),
        .o_rejected    (n_rejected),
        .o_empty_hits  (n_empty_hits)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back pressure: ready drops with a chance of about one in seven,
    // except during the steady stretch.
    initial out_ch.ready = 1'b0;
    always @(posedge clk) begin
        out_ch.ready <= steady || ($urandom_range(99) >= 14);
    end

    // Safety net in case the block hangs. The slowest correct run is well
    // under a tenth of this.
    initial begin
        #(2_000_000);
        $display("tb_sorted_priority_queue NOT OK");
        $finish;
    end

    // Sends one command and returns at the edge that accepts it. Valid stays
    // high into the next call unless that call starts with idle cycles.
    task automatic issue(input t_cmd cmd, input logic signed [VAL_W-1:0] value,
                         input logic [PRIO_W-1:0] prio);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < 14) gap++;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.item_value    <= value;
        in_ch.item_priority <= prio;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic insert(input logic signed [VAL_W-1:0] value, input logic [PRIO_W-1:0] prio);
        issue(CMD_INSERT, value, prio);
    endtask

    // The payload of a remove is ignored by the block, so it carries noise.
    task automatic remove_head();
        issue(CMD_REMOVE, $urandom, PRIO_W'($urandom_range(16'hFFFF)));
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(3))
            0:       return $signed(VAL_W'($urandom_range(8)) - VAL_W'(4));
            1:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            0:       return PRIO_W'($urandom_range(3));
            1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            2:       return PRIO_W'($urandom_range(15));
            default: return PRIO_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    initial begin
        int lean;
        int burst_left;
        int waited;

        rst_n               = 1'b0;
        steady              = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_INSERT;
        in_ch.item_value    = '0;
        in_ch.item_priority = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. A remove on the empty queue comes first, then the
        // queue is filled with extreme values, ties on priority and exact
        // duplicates, then one insert is refused because the queue is full.
        remove_head();
        insert(32'sh8000_0000, 16'h0000);
        insert(32'sh7FFF_FFFF, 16'hFFFF);
        insert(32'sh0000_0000, 16'h0000);
        insert(-32'sd1,        16'h0000);
        insert(32'sh8000_0000, 16'h0000);
        insert(32'sh7FFF_FFFF, 16'h0000);
        insert(32'sd5,         16'd7);
        insert(-32'sd5,        16'd7);
        insert(32'sh5555_5555, 16'hAAAA);
        insert(32'shAAAA_AAAA, 16'h5555);
        insert(32'sd1,         16'hFFFF);
        insert(-32'sd1,        16'hFFFF);
        insert(32'sd0,         16'h8000);
        insert(32'sd0,         16'h7FFF);
        insert(32'sd3,         16'd3);
        insert(32'sd3,         16'd3);
        insert(32'sd42,        16'd1);
        repeat (4) remove_head();

        // Random part. Bursts lean toward inserts, toward removes or toward neither, so the
        // queue swings between full and empty many times; ties and extremes
        // are frequent because most fields come from narrow pools.
        burst_left = 0;
        lean       = 50;
        for (int n = 0; n < 1428; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0:       lean = 15;
                    1:       lean = 50;
                    default: lean = 85;
                endcase
            end
            burst_left--;
            steady = (n >= 500 && n < 800);
            if ($urandom_range(99) < lean) insert(pick_value(), pick_prio());
            else                           remove_head();
        end
        steady = 1'b0;
        in_ch.valid <= 1'b0;

        // Drain: every command has one result; it is registered in the cycle after
        // acceptance and waits there until the receiver takes it.
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (outstanding != 0 && waited < 5000);
        repeat (4) @(posedge clk);

        $display("Ran %0d commands: %0d inserts, %0d removes of the head,",
                 n_inserted + n_removed + n_rejected + n_empty_hits, n_inserted, n_removed);
        $display("%0d inserts refused on a full queue, %0d removes on an empty queue.",
                 n_rejected, n_empty_hits);
        if (outstanding != 0)
            $display("%0d results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_sorted_priority_queue OK");
        end else begin
            $display("tb_sorted_priority_queue NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sv/spq_result_checker.sv
tb/sv/tb_sorted_priority_queue.sv
